>>> design/trb_pkg.sv
// Shared types and constants for the timestamp reorder buffer.
// No dependencies; compiled first.
package trb_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int SEC_W        = 32;
  localparam int TICK_W       = 3;
  localparam int KEY_W        = SEC_W + TICK_W;
  localparam int REF_W        = 32;
  localparam int POOL_W       = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SORT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_IN_USE = 1'd1;

  localparam logic [POOL_W-1:0] POOL_RESET = 7'd64;

  // request types
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_FLUSH,
    S_INSERT
  } trb_state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             pop;
    logic             ins;
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] ref_val;
  } trb_cmd_t;

endpackage

>>> design/trb_in_if.sv
// Request input channel of the reorder buffer.
// Depends on trb_pkg.
interface trb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic                       has_data;
  logic [trb_pkg::SEC_W-1:0]  event_seconds;
  logic [trb_pkg::TICK_W-1:0] rti_tick;
  logic [trb_pkg::REF_W-1:0]  packet_ref;

  modport source (output valid, req_type, has_data, event_seconds, rti_tick, packet_ref,
                  input ready);
  modport sink (input valid, req_type, has_data, event_seconds, rti_tick, packet_ref,
                output ready);
endinterface

>>> design/trb_out_if.sv
// Result output channel of the reorder buffer.
// Depends on trb_pkg.
interface trb_out_if;
  logic                       valid;
  logic                       ready;
  logic [trb_pkg::REF_W-1:0]  out_ref;
  logic [trb_pkg::SEC_W-1:0]  out_seconds;
  logic [trb_pkg::TICK_W-1:0] out_tick;
  logic                       last;

  modport source (output valid, out_ref, out_seconds, out_tick, last, input ready);
  modport sink (input valid, out_ref, out_seconds, out_tick, last, output ready);
endinterface

>>> design/trb_cfg_if.sv
// Configuration write channel of the reorder buffer.
// Depends on trb_pkg.
interface trb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [trb_pkg::CFG_IDX_W-1:0]  index;
  logic [trb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/timestamp_reorder_buffer.sv
// Top level of the timestamp reorder buffer: control, config registers,
// output register. Depends on trb_pkg, the channel interfaces, trb_chain.
//
//  channel  dir  payload                                       handshake
//  in_ch    in   req_type has_data event_seconds rti_tick ref  valid/ready
//  out_ch   out  out_ref out_seconds out_tick last             valid/ready
//  cfg_ch   in   index data                                    valid/ready
//
// Sorted insert, pass-through, drop and empty drain are all handled in S_IDLE.
// A drain holds in_ch while the store empties from the chain head; a full-store
// flush pops the oldest-time group, one result per cycle from the chain head
// while out_ch takes them, then does the deferred insert. The single output register sets the
// pace: a stall on out_ch holds the chain and in_ch.
// rst_n (synchronous) empties the store; entry contents are not cleared.
// One request is in work at a time; a new one is taken only once the output
// register is empty or its last result leaves in that same cycle.
module timestamp_reorder_buffer #(
  parameter int CAPACITY = trb_pkg::CAPACITY_DEF
) (
  input logic clk,
  input logic rst_n,
  trb_in_if.sink    in_ch,
  trb_out_if.source out_ch,
  trb_cfg_if.sink   cfg_ch
);
  import trb_pkg::*;

  localparam int FILL_W = $clog2(CAPACITY + 1);

  trb_state_t       state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic             sort_en_r;
  logic [POOL_W-1:0] pool_r;
  logic [KEY_W-1:0] pend_key_r, pend_key_nxt;
  logic [REF_W-1:0] pend_ref_r, pend_ref_nxt;

  logic             out_valid_r;
  logic [REF_W-1:0] out_ref_r, out_ref_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_load;

  trb_cmd_t         cmd;
  logic [KEY_W-1:0] head_key, second_key;
  logic [REF_W-1:0] head_ref;
  logic [FILL_W-1:0] limit;
  logic             slot_free, in_acc, head_last;
  logic [KEY_W-1:0] in_key;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_key      = {in_ch.event_seconds, in_ch.rti_tick};
  assign cfg_ch.ready = 1'b1;

  // out-of-range pool size counts as the full capacity
  always_comb begin
    if (pool_r == '0 || pool_r > POOL_W'(CAPACITY)) limit = FILL_W'(CAPACITY);
    else limit = FILL_W'(pool_r);
  end

  // flush run ends when the store empties or the next key differs
  assign head_last = (fill_r == FILL_W'(1)) || (second_key != head_key);

  trb_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk          (clk),
    .cmd          (cmd),
    .fill_i       (fill_r),
    .head_key_o   (head_key),
    .head_ref_o   (head_ref),
    .second_key_o (second_key)
  );

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    pend_key_nxt = pend_key_r;
    pend_ref_nxt = pend_ref_r;
    out_load     = 1'b0;
    out_ref_nxt  = out_ref_r;
    out_key_nxt  = out_key_r;
    out_last_nxt = out_last_r;
    cmd          = '{pop: 1'b0, ins: 1'b0, key: in_key, ref_val: in_ch.packet_ref};
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == REQ_DRAIN) begin
            if (fill_r != '0) state_nxt = S_DRAIN;
          end else if (in_ch.has_data) begin
            if (!sort_en_r) begin
              out_load     = 1'b1;
              out_ref_nxt  = in_ch.packet_ref;
              out_key_nxt  = in_key;
              out_last_nxt = 1'b1;
            end else if (fill_r >= limit) begin
              pend_key_nxt = in_key;
              pend_ref_nxt = in_ch.packet_ref;
              state_nxt    = S_FLUSH;
            end else begin
              cmd.ins  = 1'b1;
              fill_nxt = fill_r + FILL_W'(1);
            end
          end
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_ref_nxt  = head_ref;
          out_key_nxt  = head_key;
          out_last_nxt = (fill_r == FILL_W'(1));
          cmd.pop      = 1'b1;
          fill_nxt     = fill_r - FILL_W'(1);
          if (fill_r == FILL_W'(1)) state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_ref_nxt  = head_ref;
          out_key_nxt  = head_key;
          out_last_nxt = head_last;
          cmd.pop      = 1'b1;
          fill_nxt     = fill_r - FILL_W'(1);
          if (head_last) state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.ins     = 1'b1;
        cmd.key     = pend_key_r;
        cmd.ref_val = pend_ref_r;
        fill_nxt    = fill_r + FILL_W'(1);
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      sort_en_r   <= 1'b0;
      pool_r      <= POOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          REG_SORT_ENABLE: sort_en_r <= cfg_ch.data[0];
          REG_POOL_IN_USE: pool_r    <= cfg_ch.data;
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pend_key_r <= pend_key_nxt;
    pend_ref_r <= pend_ref_nxt;
    if (out_load) begin
      out_ref_r  <= out_ref_nxt;
      out_key_r  <= out_key_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_ref     = out_ref_r;
  assign out_ch.out_seconds = out_key_r[KEY_W-1:TICK_W];
  assign out_ch.out_tick    = out_key_r[TICK_W-1:0];
  assign out_ch.last        = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CAPACITY))
    else $error("store fill above capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> fill_r != '0)
    else $error("pop from empty store");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> fill_r < FILL_W'(CAPACITY))
    else $error("insert into full store");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && out_load && out_last_nxt) |=> fill_r == '0)
    else $error("drain ended with entries left");

  a_insert_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INSERT |=> state_r == S_IDLE)
    else $error("deferred insert did not return to idle");

endmodule

>>> design/trb_cell.sv
// One entry of the sorted chain: holds a key and a packet reference.
// Depends on trb_pkg.
module trb_cell (
  input  logic                      clk,
  input  trb_pkg::trb_cmd_t         cmd,
  input  logic                      valid_i,
  input  logic                      prev_le_i,
  input  logic [trb_pkg::KEY_W-1:0] prev_key_i,
  input  logic [trb_pkg::REF_W-1:0] prev_ref_i,
  input  logic [trb_pkg::KEY_W-1:0] next_key_i,
  input  logic [trb_pkg::REF_W-1:0] next_ref_i,
  output logic [trb_pkg::KEY_W-1:0] key_o,
  output logic [trb_pkg::REF_W-1:0] ref_o,
  output logic                      le_o
);
  import trb_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [REF_W-1:0] ref_r, ref_nxt;

  // new key goes behind this entry (ties keep arrival order)
  assign le_o = valid_i && (key_r <= cmd.key);

  always_comb begin
    key_nxt = key_r;
    ref_nxt = ref_r;
    if (cmd.pop) begin
      key_nxt = next_key_i;
      ref_nxt = next_ref_i;
    end else if (cmd.ins && !le_o) begin
      if (prev_le_i) begin
        key_nxt = cmd.key;
        ref_nxt = cmd.ref_val;
      end else begin
        key_nxt = prev_key_i;
        ref_nxt = prev_ref_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    ref_r <= ref_nxt;
  end

  assign key_o = key_r;
  assign ref_o = ref_r;

endmodule

>>> design/trb_chain.sv
// Row of CAPACITY cells forming the sorted store; shifts left on pop,
// opens a gap and shifts right on insert. Depends on trb_pkg, trb_cell.
module trb_chain #(
  parameter int CAPACITY = trb_pkg::CAPACITY_DEF,
  localparam int FILL_W  = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  trb_pkg::trb_cmd_t         cmd,
  input  logic [FILL_W-1:0]         fill_i,
  output logic [trb_pkg::KEY_W-1:0] head_key_o,
  output logic [trb_pkg::REF_W-1:0] head_ref_o,
  output logic [trb_pkg::KEY_W-1:0] second_key_o
);
  import trb_pkg::*;

  logic [KEY_W-1:0] key_w [CAPACITY];
  logic [REF_W-1:0] ref_w [CAPACITY];
  logic             le_w  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             prev_le;
    logic [KEY_W-1:0] prev_key, next_key;
    logic [REF_W-1:0] prev_ref, next_ref;

    if (i == 0) begin : g_first
      assign prev_le  = 1'b1;
      assign prev_key = key_w[i];
      assign prev_ref = ref_w[i];
    end else begin : g_mid
      assign prev_le  = le_w[i-1];
      assign prev_key = key_w[i-1];
      assign prev_ref = ref_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = key_w[i];
      assign next_ref = ref_w[i];
    end else begin : g_inner
      assign next_key = key_w[i+1];
      assign next_ref = ref_w[i+1];
    end

    trb_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid_i    (FILL_W'(i) < fill_i),
      .prev_le_i  (prev_le),
      .prev_key_i (prev_key),
      .prev_ref_i (prev_ref),
      .next_key_i (next_key),
      .next_ref_i (next_ref),
      .key_o      (key_w[i]),
      .ref_o      (ref_w[i]),
      .le_o       (le_w[i])
    );
  end

  assign head_key_o   = key_w[0];
  assign head_ref_o   = ref_w[0];
  assign second_key_o = key_w[1];

endmodule

>>> dv/trb_order_checker.sv
`timescale 1ns / 100ps
// Watches the request, result and config channels of the reorder buffer and
// predicts the time-ordered results. Depends on trb_pkg and the channel interfaces.
module trb_order_checker #(
  parameter int CAPACITY = trb_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  trb_in_if    in_mon,
  trb_out_if   out_mon,
  trb_cfg_if   cfg_mon,
  output int   errors,
  output int   pending
);
  import trb_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] pkt_ref;
  } slot_t;

  typedef struct packed {
    logic [REF_W-1:0]  pkt_ref;
    logic [SEC_W-1:0]  secs;
    logic [TICK_W-1:0] tick;
    logic              last;
  } emit_t;

  slot_t             sorted_q[$];   // model of the sorted store, head first
  emit_t             due_q[$];      // results still owed by the block
  logic              sort_on;
  logic [POOL_W-1:0] pool_lim;
  int                err_cnt = 0;
  int                due_cnt = 0;

  assign errors  = err_cnt;
  assign pending = due_cnt;

  function automatic void emit_head();
    slot_t s;
    emit_t r;
    s = sorted_q.pop_front();
    r.pkt_ref = s.pkt_ref;
    r.secs    = s.key[KEY_W-1:TICK_W];
    r.tick    = s.key[TICK_W-1:0];
    r.last    = 1'b0;
    due_q.push_back(r);
  endfunction

  function automatic void predict_request(input logic req, input logic has_data,
                                          input logic [SEC_W-1:0] secs,
                                          input logic [TICK_W-1:0] tick,
                                          input logic [REF_W-1:0] pkt_ref);
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] head_key;
    int               n;
    int               lim;
    int               pos;
    slot_t            s;
    emit_t            r;
    key = {secs, tick};
    n   = 0;
    if (req == REQ_DRAIN) begin
      while (sorted_q.size() > 0) begin
        emit_head();
        n++;
      end
    end else if (has_data) begin
      if (!sort_on) begin
        r.pkt_ref = pkt_ref;
        r.secs    = secs;
        r.tick    = tick;
        r.last    = 1'b1;
        due_q.push_back(r);
      end else begin
        lim = int'(pool_lim);
        if (lim == 0 || lim > CAPACITY) lim = CAPACITY;
        // full (or shrunk) store: release the whole oldest-time group first
        if (sorted_q.size() >= lim && sorted_q.size() > 0) begin
          head_key = sorted_q[0].key;
          while (sorted_q.size() > 0 && sorted_q[0].key == head_key) begin
            emit_head();
            n++;
          end
        end
        if (sorted_q.size() < CAPACITY) begin
          pos = 0;
          while (pos < sorted_q.size() && sorted_q[pos].key <= key) pos++;
          s.key     = key;
          s.pkt_ref = pkt_ref;
          sorted_q.insert(pos, s);
        end
      end
    end
    if (n > 0) begin
      r = due_q.pop_back();
      r.last = 1'b1;
      due_q.push_back(r);
    end
  endfunction

  function automatic void cmp_field(input string fname, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      err_cnt++;
    end
  endfunction

  function automatic void check_result();
    emit_t want;
    if (due_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual ref=%h secs=%h tick=%0d last=%0b",
               $time, out_mon.out_ref, out_mon.out_seconds, out_mon.out_tick,
               out_mon.last);
      err_cnt++;
    end else begin
      want = due_q.pop_front();
      cmp_field("out_ref", 64'(want.pkt_ref), 64'(out_mon.out_ref));
      cmp_field("out_seconds", 64'(want.secs), 64'(out_mon.out_seconds));
      cmp_field("out_tick", 64'(want.tick), 64'(out_mon.out_tick));
      cmp_field("last", 64'(want.last), 64'(out_mon.last));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sorted_q.delete();
      due_q.delete();
      sort_on  = 1'b0;
      pool_lim = POOL_RESET;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SORT_ENABLE: sort_on  = cfg_mon.data[0];
          REG_POOL_IN_USE: pool_lim = cfg_mon.data[POOL_W-1:0];
          default: ;
        endcase
      end
      // a result never belongs to the request taken at the same edge
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        predict_request(in_mon.req_type, in_mon.has_data, in_mon.event_seconds,
                        in_mon.rti_tick, in_mon.packet_ref);
    end
    due_cnt = due_q.size();
  end

endmodule

>>> dv/timestamp_reorder_buffer_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the timestamp reorder buffer: directed cases, then
// random phases under changing config. Depends on trb_pkg, the interfaces, trb_order_checker.
module timestamp_reorder_buffer_tb;
  import trb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors;
  int   pending;
  bit   calm = 1'b0;      // no idling on either side
  int   gap_pct = 20;
  int   stall_pct = 10;

  trb_in_if  in_ch();
  trb_out_if out_ch();
  trb_cfg_if cfg_ch();

  timestamp_reorder_buffer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  trb_order_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[timestamp_reorder_buffer] ERROR");
    $finish;
  end

  // result side back-pressure in bursts
  initial begin : sink_pace
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0 && !calm) begin
        hold--;
        out_ch.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 12) - 1;
        out_ch.ready = 1'b0;
      end else begin
        hold = 0;
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_req(input logic req, input logic has_data,
                          input logic [SEC_W-1:0] secs, input logic [TICK_W-1:0] tick,
                          input logic [REF_W-1:0] pkt_ref);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.req_type      = req;
    in_ch.has_data      = has_data;
    in_ch.event_seconds = secs;
    in_ch.rti_tick      = tick;
    in_ch.packet_ref    = pkt_ref;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold off until every owed result is out, plus room for a deferred insert
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // mostly clustered times so that ties and small groups are common
  function automatic logic [SEC_W-1:0] pick_secs(input logic [SEC_W-1:0] base);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return base + SEC_W'($urandom_range(0, 7));
    else if (sel < 9) return base + SEC_W'($urandom_range(0, 300));
    else return $urandom;
  endfunction

  task automatic random_item(input logic [SEC_W-1:0] base, output bit counted);
    logic req;
    logic has_data;
    req      = ($urandom_range(0, 99) < 3) ? REQ_DRAIN : REQ_PACKET;
    has_data = ($urandom_range(0, 99) < 90);
    counted  = (req == REQ_DRAIN) || has_data;
    send_req(req, has_data, pick_secs(base), TICK_W'($urandom), $urandom);
  endtask

  initial begin : stimulus
    int                ph;
    int                n;
    int                cnt;
    bit                counted;
    logic [SEC_W-1:0]  base;
    logic [POOL_W-1:0] pool_v;

    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_PACKET;
    in_ch.has_data      = 1'b0;
    in_ch.event_seconds = '0;
    in_ch.rti_tick      = '0;
    in_ch.packet_ref    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_SORT_ENABLE;
    cfg_ch.data         = '0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset config: pass-through
    send_req(REQ_PACKET, 1'b1, 32'h0, 3'd0, 32'h0);
    send_req(REQ_PACKET, 1'b1, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    send_req(REQ_PACKET, 1'b0, 32'd123, 3'd3, 32'h55);           // dropped
    send_req(REQ_DRAIN, 1'b0, 32'd0, 3'd0, 32'h0);               // empty drain

    wait_drained();
    cfg_write(REG_SORT_ENABLE, 7'd1);
    cfg_write(REG_POOL_IN_USE, 7'd4);
    send_req(REQ_PACKET, 1'b1, 32'd10, 3'd5, 32'hA1);
    send_req(REQ_PACKET, 1'b1, 32'd10, 3'd2, 32'hA2);
    send_req(REQ_PACKET, 1'b1, 32'd10, 3'd2, 32'hA3);            // tie
    send_req(REQ_PACKET, 1'b0, 32'd1, 3'd1, 32'hDEAD);           // dropped
    send_req(REQ_PACKET, 1'b1, 32'hFFFF_FFFF, 3'd7, 32'hA4);
    send_req(REQ_PACKET, 1'b1, 32'd0, 3'd0, 32'hA5);             // full: group flush

    // pool shrunk below fill
    wait_drained();
    cfg_write(REG_POOL_IN_USE, 7'd2);
    send_req(REQ_PACKET, 1'b1, 32'd10, 3'd5, 32'hA6);

    // pass-through leaves the store alone, drain still empties it
    wait_drained();
    cfg_write(REG_SORT_ENABLE, 7'd0);
    send_req(REQ_PACKET, 1'b1, 32'd7, 3'd1, 32'hA7);
    send_req(REQ_DRAIN, 1'b1, 32'd0, 3'd0, 32'h0);

    // flush that empties the store
    wait_drained();
    cfg_write(REG_SORT_ENABLE, 7'd1);
    cfg_write(REG_POOL_IN_USE, 7'd1);
    send_req(REQ_PACKET, 1'b1, 32'd5, 3'd0, 32'hB1);
    send_req(REQ_PACKET, 1'b1, 32'd3, 3'd0, 32'hB2);
    wait_drained();
    cfg_write(REG_POOL_IN_USE, 7'd3);
    send_req(REQ_PACKET, 1'b1, 32'd3, 3'd0, 32'hB3);
    send_req(REQ_PACKET, 1'b1, 32'd3, 3'd0, 32'hB4);
    send_req(REQ_PACKET, 1'b1, 32'd1, 3'd1, 32'hB5);

    // out-of-range pool sizes count as full capacity
    wait_drained();
    cfg_write(REG_POOL_IN_USE, 7'd0);
    send_req(REQ_PACKET, 1'b1, 32'h8000_0000, 3'd4, 32'h5A5A_5A5A);
    wait_drained();
    cfg_write(REG_POOL_IN_USE, 7'd127);
    send_req(REQ_PACKET, 1'b1, 32'h7FFF_FFFF, 3'd3, 32'hA5A5_A5A5);
    send_req(REQ_DRAIN, 1'b0, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);

    for (ph = 0; ph < 9; ph++) begin
      wait_drained();
      case ($urandom_range(0, 7))
        0:       pool_v = 7'd1;
        1:       pool_v = 7'd2;
        2:       pool_v = POOL_RESET;
        3:       pool_v = 7'd0;
        4:       pool_v = 7'($urandom_range(65, 127));
        default: pool_v = 7'($urandom_range(1, 8));
      endcase
      n = $urandom_range(30, 55);
      if (ph == 3) begin
        // fill the whole store with clustered times
        pool_v = POOL_RESET;
        n      = 90;
      end
      cfg_write(REG_SORT_ENABLE, ($urandom_range(0, 99) < 85 || ph == 3) ? 7'd1 : 7'd0);
      cfg_write(REG_POOL_IN_USE, pool_v);
      gap_pct   = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
      stall_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
      case ($urandom_range(0, 3))
        0:       base = 32'h0;
        1:       base = 32'hFFFF_FF00;
        default: base = $urandom;
      endcase
      cnt = 0;
      while (cnt < n) begin
        random_item(base, counted);
        if (counted) cnt++;
        if (base != 32'h0 && $urandom_range(0, 19) == 0) base = base + 32'd3;
      end
      if (ph == 3 || $urandom_range(0, 1) == 1)
        send_req(REQ_DRAIN, 1'b0, $urandom, TICK_W'($urandom), $urandom);
    end

    // closing stretch at full rate
    wait_drained();
    calm = 1'b1;
    cfg_write(REG_SORT_ENABLE, 7'd1);
    cfg_write(REG_POOL_IN_USE, 7'($urandom_range(1, 6)));
    base = $urandom;
    cnt  = 0;
    while (cnt < 50) begin
      random_item(base, counted);
      if (counted) cnt++;
    end
    send_req(REQ_DRAIN, 1'b0, 32'd0, 3'd0, 32'd0);

    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[timestamp_reorder_buffer] OK");
    end else begin
      $display("[timestamp_reorder_buffer] ERROR");
    end
    $finish;
  end

endmodule
